/* hdl/tsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg
// shared types and constants for the two-way sorted merge block
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int DATA_W          = 32;
    localparam int LIST_DEPTH_DEF  = 32;

    // command codes
    localparam logic [1:0] OP_APPEND_A = 2'd0;
    localparam logic [1:0] OP_APPEND_B = 2'd1;
    localparam logic [1:0] OP_MERGE    = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] merged_value;
        logic                     last;
        logic                     empty_res;
        logic                     overflow;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MERGE
    } t_state;

endpackage

/* hdl/tsm_list_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_list_mem
// one list store: single write port, single registered read port
// ----------------------------------------------------------------------------
module tsm_list_mem
    import tsm_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF,
    parameter int AW    = 5
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/tsm_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_seq
// command sequencer, list counters, shared signed comparator, result register
// ----------------------------------------------------------------------------
module tsm_seq
    import tsm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int AW         = 5,
    parameter int CW         = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_in                      i_item,
    output logic                     o_busy,
    output logic                     o_wr_en_a,
    output logic                     o_wr_en_b,
    output logic [AW-1:0]            o_wr_addr_a,
    output logic [AW-1:0]            o_wr_addr_b,
    output logic [AW-1:0]            o_rd_addr_a,
    output logic [AW-1:0]            o_rd_addr_b,
    input  logic signed [DATA_W-1:0] i_rd_a,
    input  logic signed [DATA_W-1:0] i_rd_b,
    output logic                     o_strobe,
    output t_out                     o_result
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ia, n_ia;
    logic [CW-1:0] r_ib, n_ib;
    logic          r_dropped, n_dropped;
    logic          r_strobe, n_strobe;
    t_out          r_out, n_out;

    logic          a_ok;
    logic          b_ok;
    logic          take_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_ia      <= '0;
            r_ib      <= '0;
            r_dropped <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_a   <= n_cnt_a;
            r_cnt_b   <= n_cnt_b;
            r_ia      <= n_ia;
            r_ib      <= n_ib;
            r_dropped <= n_dropped;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // comparator: list a wins on ties
    assign a_ok   = (r_ia < r_cnt_a);
    assign b_ok   = (r_ib < r_cnt_b);
    assign take_a = a_ok && (!b_ok || (i_rd_a <= i_rd_b));

    always_comb begin
        n_state   = r_state;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_ia      = r_ia;
        n_ib      = r_ib;
        n_dropped = r_dropped;
        n_strobe  = 1'b0;
        n_out     = r_out;
        o_wr_en_a = 1'b0;
        o_wr_en_b = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_item.opcode)
                        OP_APPEND_A: begin
                            if (r_cnt_a < CW'(LIST_DEPTH)) begin
                                o_wr_en_a = 1'b1;
                                n_cnt_a   = r_cnt_a + 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        OP_APPEND_B: begin
                            if (r_cnt_b < CW'(LIST_DEPTH)) begin
                                o_wr_en_b = 1'b1;
                                n_cnt_b   = r_cnt_b + 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        OP_MERGE: begin
                            if ((r_cnt_a == '0) && (r_cnt_b == '0)) begin
                                n_strobe           = 1'b1;
                                n_out.merged_value = '0;
                                n_out.last         = 1'b1;
                                n_out.empty_res    = 1'b1;
                                n_out.overflow     = r_dropped;
                                n_dropped          = 1'b0;
                            end else begin
                                n_state = ST_LOAD;
                                n_ia    = '0;
                                n_ib    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                n_strobe           = 1'b1;
                n_out.merged_value = take_a ? i_rd_a : i_rd_b;
                n_out.empty_res    = 1'b0;
                n_out.overflow     = r_dropped;
                if (take_a) begin
                    n_ia = r_ia + 1'b1;
                end else begin
                    n_ib = r_ib + 1'b1;
                end
                n_out.last = (n_ia == r_cnt_a) && (n_ib == r_cnt_b);
                if (n_out.last) begin
                    n_state   = ST_IDLE;
                    n_cnt_a   = '0;
                    n_cnt_b   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // read next index so data lines up with the index register
    assign o_rd_addr_a = n_ia[AW-1:0];
    assign o_rd_addr_b = n_ib[AW-1:0];
    assign o_wr_addr_a = r_cnt_a[AW-1:0];
    assign o_wr_addr_b = r_cnt_b[AW-1:0];
    assign o_busy      = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;

endmodule

/* hdl/two_way_sorted_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_sorted_merge
// merges two appended lists of signed values, list a first on ties
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  command   start, busy, i_item         taken when start high and busy low
//  result    o_strobe, o_result          one result per strobe, no back-pressure
//
//  append transaction: busy stays low, no result
//  merge of n stored entries: busy through a load state (covering the read
//  latency), then one entry per cycle through the shared comparator; results
//  appear one per cycle, registered after each compare, the last in the first
//  cycle with busy low
//  merge with both lists empty: one result on the next cycle, busy stays low
//  reset: synchronous, active low, clears both lists, counters and the flag
//  the receiver cannot stall; results leave as they are produced
// ----------------------------------------------------------------------------
module two_way_sorted_merge
    import tsm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    // address width for the stores, count width able to hold the depth itself
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic                     wr_en_a;
    logic                     wr_en_b;
    logic [AW-1:0]            wr_addr_a;
    logic [AW-1:0]            wr_addr_b;
    logic [AW-1:0]            rd_addr_a;
    logic [AW-1:0]            rd_addr_b;
    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;

    // list a store
    tsm_list_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_mem_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en_a),
        .i_wr_addr (wr_addr_a),
        .i_wr_data (i_item.value),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (rd_a)
    );

    // list b store
    tsm_list_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_mem_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en_b),
        .i_wr_addr (wr_addr_b),
        .i_wr_data (i_item.value),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (rd_b)
    );

    // sequencer walks both lists, one compare and one result per cycle
    tsm_seq #(
        .LIST_DEPTH (LIST_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .o_busy      (busy),
        .o_wr_en_a   (wr_en_a),
        .o_wr_en_b   (wr_en_b),
        .o_wr_addr_a (wr_addr_a),
        .o_wr_addr_b (wr_addr_b),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

/* hdl/tsm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_checker
// port-level checks on command and result behavior over time
// ----------------------------------------------------------------------------
module tsm_checker
    import tsm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_item,
    input logic o_strobe,
    input t_out o_result
);

    // no result in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // an empty-list result is the last one and carries zero
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.empty_res) |->
            (o_result.last && (o_result.merged_value == '0)))
        else $error("empty result not last or nonzero");

    // a merge transaction either answers at once or goes busy
    a_merge_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode == OP_MERGE)) |=> (o_strobe || busy))
        else $error("merge transaction left no trace");

    // an append transaction gives no result
    a_append_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy &&
         ((i_item.opcode == OP_APPEND_A) || (i_item.opcode == OP_APPEND_B)))
            |=> !o_strobe)
        else $error("append transaction produced a result");

endmodule

bind two_way_sorted_merge tsm_checker u_tsm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
